### hw/rtl/timestamp_root_code_encoder_assert.svh
// ----------------------------------------------------------------------------
// Timestamp root code encoder - assertion macros
// Shared property macros for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_ROOT_CODE_ENCODER_ASSERT_SVH
`define TIMESTAMP_ROOT_CODE_ENCODER_ASSERT_SVH

// same-cycle implication
`define TSRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsrc: same-cycle check failed");

// next-cycle implication
`define TSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsrc: next-cycle check failed");

`endif

### hw/rtl/tsrc_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp root code encoder - package
// Shared types, constants and the digit-to-character function.
// ----------------------------------------------------------------------------
package tsrc_pkg;

    localparam int TSRC_IN_W     = 72;
    localparam int TSRC_OUT_W    = 48;
    localparam int TSRC_USER_W   = 2;
    localparam int TSRC_NUM_CELLS = 5;

    localparam logic [31:0] TSRC_BREAK_RESET = 32'd1519659904;

    // legacy period weights
    localparam logic [31:0] TSRC_SCALE_YEAR = 32'd7884000;
    localparam logic [31:0] TSRC_SCALE_DAY  = 32'd21600;
    localparam logic [31:0] TSRC_SCALE_HOUR = 32'd900;
    localparam logic [31:0] TSRC_SCALE_MIN  = 32'd15;

    // reciprocals: q = (v * M) >> K, exact for any 32-bit v
    localparam logic [31:0] TSRC_RECIP_36 = 32'd3817748708;
    localparam int          TSRC_SHIFT_36 = 37;
    localparam logic [31:0] TSRC_RECIP_26 = 32'd2643056798;
    localparam int          TSRC_SHIFT_26 = 36;

    localparam logic [7:0] TSRC_CH_ZERO  = 8'h30;
    localparam logic [7:0] TSRC_CH_UPPER = 8'h41;
    localparam logic [7:0] TSRC_CH_LOWER = 8'h61;
    localparam logic [7:0] TSRC_DEC_BASE = 8'd10;

    typedef struct packed {
        logic [31:0]     val;
        logic            new_fmt;
        logic            bad;
        logic [4:0][7:0] lo_chars;  // [4] = sixth char .. [0] = second char
    } t_word;

    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_front_ctl;

    function automatic logic [7:0] tsrc_digit_char(input logic [7:0] d,
                                                   input logic new_fmt);
        logic [7:0] c;
        if (new_fmt) begin
            if (d < TSRC_DEC_BASE) begin
                c = TSRC_CH_ZERO + d;
            end else begin
                c = TSRC_CH_UPPER + d - TSRC_DEC_BASE;
            end
        end else begin
            c = TSRC_CH_LOWER + d;
        end
        return c;
    endfunction

endpackage

### hw/rtl/tsrc_front.sv
// ----------------------------------------------------------------------------
// Timestamp root code encoder - front end
// Two stages: format select and date checks, then the legacy period sum.
// ----------------------------------------------------------------------------
module tsrc_front import tsrc_pkg::*; (
    input  logic                 i_clk,
    input  t_front_ctl           i_ctl,
    input  logic [31:0]          i_break_epoch,
    input  logic [TSRC_IN_W-1:0] i_tdata,
    output t_word                o_word
);

    logic [31:0] epoch;
    logic [7:0]  year;
    logic [8:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  sec;

    logic [32:0] diff;
    logic [7:0]  year_mod;
    logic [6:0]  y_lo;
    logic [6:0]  y79;
    logic [7:0]  y79_p2;
    logic [6:0]  y79_p3;
    logic [9:0]  day_adj;
    logic        bad;

    logic        r_new;
    logic        r_bad;
    logic [31:0] r_u;
    logic [6:0]  r_y79;
    logic [9:0]  r_day_adj;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [7:0]  r_sec;

    logic [31:0] periods;
    t_word       n_word;
    t_word       r_word;

    assign epoch  = i_tdata[31:0];
    assign year   = i_tdata[39:32];
    assign day    = i_tdata[48:40];
    assign hour   = i_tdata[53:49];
    assign minute = i_tdata[59:54];
    assign sec    = i_tdata[67:60];

    assign diff = {1'b0, epoch} - {1'b0, i_break_epoch};

    always_comb begin
        if (year >= 8'd200) begin
            year_mod = year - 8'd200;
        end else if (year >= 8'd100) begin
            year_mod = year - 8'd100;
        end else begin
            year_mod = year;
        end
    end

    assign y_lo    = year_mod[6:0];
    assign y79     = (y_lo >= 7'd79) ? (y_lo - 7'd79) : (y_lo + 7'd21);
    assign y79_p2  = {1'b0, y79} + 8'd2;
    assign y79_p3  = y79 + 7'd3;
    assign day_adj = {1'b0, day} + {4'b0, y79_p2[7:2]} - 10'd1;

    assign bad = (day == 9'd0) || (day > 9'd366)
              || ((day == 9'd366) && (y79_p3[1:0] != 2'd0))
              || (hour > 5'd23) || (minute > 6'd59);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_new     <= ~diff[32];
            r_bad     <= diff[32] & bad;
            r_u       <= diff[31:0];
            r_y79     <= y79;
            r_day_adj <= day_adj;
            r_hour    <= hour;
            r_min     <= minute;
            r_sec     <= sec;
        end
    end

    assign periods = 32'(r_y79) * TSRC_SCALE_YEAR
                   + 32'(r_day_adj) * TSRC_SCALE_DAY
                   + 32'(r_hour) * TSRC_SCALE_HOUR
                   + 32'(r_min) * TSRC_SCALE_MIN
                   + 32'(r_sec[7:2]);

    always_comb begin
        n_word          = '0;
        n_word.val      = r_new ? r_u : periods;
        n_word.new_fmt  = r_new;
        n_word.bad      = r_bad;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_b) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

### hw/rtl/tsrc_cell.sv
// ----------------------------------------------------------------------------
// Timestamp root code encoder - digit cell
// Peels the low digit off the value, emits its character, passes the quotient.
// ----------------------------------------------------------------------------
module tsrc_cell import tsrc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_word,
    output t_word o_word
);

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] quot_x_base;
    logic [5:0]  rem;
    t_word       n_word;
    t_word       r_word;

    assign prod = 64'(i_word.val) * 64'(i_word.new_fmt ? TSRC_RECIP_36 : TSRC_RECIP_26);
    assign quot = i_word.new_fmt ? 32'(prod >> TSRC_SHIFT_36) : 32'(prod >> TSRC_SHIFT_26);

    // q*36 or q*26 as shift-add
    assign quot_x_base = i_word.new_fmt ? ((quot << 5) + (quot << 2))
                                        : ((quot << 4) + (quot << 3) + (quot << 1));
    assign rem = i_word.val[5:0] - quot_x_base[5:0];

    always_comb begin
        n_word          = i_word;
        n_word.val      = quot;
        n_word.lo_chars = {i_word.lo_chars[3:0], tsrc_digit_char({2'b0, rem}, i_word.new_fmt)};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

### hw/rtl/timestamp_root_code_encoder.sv
// ----------------------------------------------------------------------------
// Timestamp root code encoder - top level
// Six-character root code from a timestamp, base-36 or legacy base-26.
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless a stalled output has filled every stage,
// and passes each code through two front stages (format select, date checks,
// legacy period sum), a chain of five digit cells that each strip one low
// digit with a reciprocal multiply, and an output register that forms the top
// character. Every stage has its own valid bit, so bubbles close up under a
// stalled output. Write the break epoch only while the encoder is empty.
`include "timestamp_root_code_encoder_assert.svh"

module timestamp_root_code_encoder import tsrc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_wdata,   // break_epoch
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // epoch_seconds, years_since_1900, day_of_year, hour_of_day,
    // minute_of_hour, second_count, zero pad
    input  logic [TSRC_IN_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // char_first, char_second, char_third, char_fourth, char_fifth, char_sixth
    output logic [TSRC_OUT_W-1:0]  m_axis_tdata,
    // new_format, invalid
    output logic [TSRC_USER_W-1:0] m_axis_tuser
);

    localparam int NSTG = TSRC_NUM_CELLS + 3;

    logic [31:0]     r_break_epoch;
    logic [NSTG-1:0] r_valid;
    logic [NSTG:0]   stg_rdy;
    logic [NSTG-1:0] stg_load;
    logic [NSTG-1:0] prev_valid;

    t_front_ctl      front_ctl;
    t_word           chain [0:TSRC_NUM_CELLS];
    logic [7:0]      top_char;

    logic [TSRC_OUT_W-1:0]  r_tdata;
    logic [TSRC_USER_W-1:0] r_tuser;

    logic [7:0]      low_char;
    logic            low_b36_ok;
    logic            low_b26_ok;
    logic            out_bad;
    logic            out_b36;
    logic            out_b26;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_epoch <= TSRC_BREAK_RESET;
        end else if (i_cfg_we) begin
            r_break_epoch <= i_cfg_wdata;
        end
    end

    assign prev_valid = {r_valid[NSTG-2:0], s_axis_tvalid};

    always_comb begin
        stg_rdy[NSTG] = m_axis_tready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            stg_rdy[i] = ~r_valid[i] | stg_rdy[i+1];
        end
    end

    assign stg_load = stg_rdy[NSTG-1:0] & prev_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stg_rdy[i]) begin
                    r_valid[i] <= prev_valid[i];
                end
            end
        end
    end

    assign s_axis_tready = stg_rdy[0];

    assign front_ctl.en_a = stg_load[0];
    assign front_ctl.en_b = stg_load[1];

    tsrc_front u_front (
        .i_clk         (i_clk),
        .i_ctl         (front_ctl),
        .i_break_epoch (r_break_epoch),
        .i_tdata       (s_axis_tdata),
        .o_word        (chain[0])
    );

    for (genvar g = 0; g < TSRC_NUM_CELLS; g++) begin : g_cell
        tsrc_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (stg_load[g+2]),
            .i_word (chain[g]),
            .o_word (chain[g+1])
        );
    end

    assign top_char = tsrc_digit_char(chain[TSRC_NUM_CELLS].val[7:0],
                                      chain[TSRC_NUM_CELLS].new_fmt);

    always_ff @(posedge i_clk) begin
        if (stg_load[NSTG-1]) begin
            r_tdata <= chain[TSRC_NUM_CELLS].bad ? '0
                     : {chain[TSRC_NUM_CELLS].lo_chars, top_char};
            r_tuser <= {chain[TSRC_NUM_CELLS].bad, chain[TSRC_NUM_CELLS].new_fmt};
        end
    end

    assign m_axis_tvalid = r_valid[NSTG-1];
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;

    assign low_char   = m_axis_tdata[TSRC_OUT_W-1 -: 8];
    assign low_b36_ok = (low_char >= 8'h30 && low_char <= 8'h39)
                     || (low_char >= 8'h41 && low_char <= 8'h5A);
    assign low_b26_ok = (low_char >= 8'h61) && (low_char <= 8'h7A);
    assign out_bad    = m_axis_tvalid && m_axis_tuser[1];
    assign out_b36    = m_axis_tvalid && m_axis_tuser[0];
    assign out_b26    = m_axis_tvalid && (m_axis_tuser == 2'b00);

    `TSRC_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_valid[0])
    `TSRC_ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, out_bad, m_axis_tdata == '0)
    `TSRC_ASSERT_IMPL(a_invalid_legacy, i_clk, i_rst_n, out_bad, !m_axis_tuser[0])
    `TSRC_ASSERT_IMPL(a_b36_low_char, i_clk, i_rst_n, out_b36, low_b36_ok)
    `TSRC_ASSERT_IMPL(a_b26_low_char, i_clk, i_rst_n, out_b26, low_b26_ok)

endmodule
